// ===== rtl/cmt_pkg.sv =====
// Shared types, sizes and helper functions of the CMAC map and train unit.
// Used by the quantizer front end, the job queue, the cell sequencer and the top level.
`default_nettype none

package cmt_pkg;

    localparam int NUM_CELLS    = 5;
    localparam int RES_Y0       = 64;
    localparam int RES_Y1       = 64;
    // Must be a power of two; addresses wrap by keeping the low bits.
    localparam int WEIGHT_DEPTH = 256;

    localparam int RES_MAX   = (RES_Y0 > RES_Y1) ? RES_Y0 : RES_Y1;
    localparam int LVL_W     = $clog2(RES_MAX);
    localparam int NUM_W     = 16 + LVL_W;
    localparam int NUM_CNT_W = $clog2(NUM_W + 1);
    localparam int DSUM_W    = $clog2(RES_MAX + 15);
    localparam int ADDR_W    = $clog2(WEIGHT_DEPTH);
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int R1        = (RES_Y1 - 2) / NUM_CELLS + 2;
    localparam int R1_W      = $clog2(R1 + 1);
    localparam int LIN_W     = ADDR_W + DSUM_W + R1_W;

    localparam int SUM_W     = 35;
    localparam int ERR_W     = 36;
    localparam int MAG_W     = 36;
    localparam int INC_W     = 37;
    localparam int MAGCNT_W  = $clog2(MAG_W + 1);
    localparam int DREM_W    = $clog2(NUM_CELLS) + 2;

    // The increment is divided by the cell count in twelve-bit digits.
    localparam int DIV_DIGIT_W = 12;
    localparam int DIV_STEPS   = MAG_W / DIV_DIGIT_W;
    localparam int DSH_W       = DREM_W + DIV_DIGIT_W;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    // Reciprocal of the cell count, exact for the level sums and the division
    // digits used here.
    localparam int RECIP_SH  = 24;
    localparam int RECIP_W   = 25;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SH + NUM_CELLS - 1) / NUM_CELLS);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_TABLE = 3'd5;

    typedef struct packed {
        logic                    mode;
        logic [LVL_W-1:0]        q0;
        logic [LVL_W-1:0]        q1;
        logic signed [31:0]      target0;
        logic signed [31:0]      target1;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ADDR,
        B_SUM_RD,
        B_SUM_ACC,
        B_RESULT,
        B_INC,
        B_DIV,
        B_UPD_RD,
        B_UPD_WR
    } back_state_t;

    function automatic logic [DSUM_W-1:0] div_cells(input logic [DSUM_W-1:0] v);
        logic [DSUM_W+RECIP_W-1:0] prod;
        prod = (DSUM_W + RECIP_W)'(v) * (DSUM_W + RECIP_W)'(RECIP);
        return prod[RECIP_SH +: DSUM_W];
    endfunction

    // One quotient digit of the long division by the cell count; the upper bits
    // of v hold the remainder of the previous digit.
    function automatic logic [DIV_DIGIT_W-1:0] div_digit(input logic [DSH_W-1:0] v);
        logic [DSH_W+RECIP_W-1:0] prod;
        prod = (DSH_W + RECIP_W)'(v) * (DSH_W + RECIP_W)'(RECIP);
        return prod[RECIP_SH +: DIV_DIGIT_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cmt_front.sv =====
// Front end: takes input beats, clamps and quantizes both samples with a
// bit-serial divider, and pushes a job into the queue. Depends on cmt_pkg.
`default_nettype none

module cmt_front
    import cmt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_mode,
    input  wire logic [15:0]        in_y0,
    input  wire logic [15:0]        in_y1,
    input  wire logic signed [31:0] in_target0,
    input  wire logic signed [31:0] in_target1,
    input  wire logic [15:0]        min_y0,
    input  wire logic [15:0]        max_y0,
    input  wire logic [15:0]        min_y1,
    input  wire logic [15:0]        max_y1,
    input  wire logic               full,
    output logic                    push,
    output job_t                    job
);

    front_state_t state_reg, state_next;

    logic [NUM_CNT_W-1:0] cnt_reg;
    logic                 mode_reg;
    logic signed [31:0]   t0_reg, t1_reg;
    logic [NUM_W-1:0]     num0_reg, num1_reg;
    logic [NUM_W-1:0]     quot0_reg, quot1_reg;
    logic [15:0]          den0_reg, den1_reg;
    logic [15:0]          rem0_reg, rem1_reg;
    logic                 empty0_reg, empty1_reg;

    logic        accept;
    logic [15:0] yc0, yc1;
    logic [16:0] rsh0, rsh1;
    logic        ge0, ge1;

    function automatic logic [15:0] clamp(input logic [15:0] y, input logic [15:0] lo,
                                          input logic [15:0] hi);
        logic [15:0] r;
        r = y;
        if (y < lo)
        begin
            r = lo;
        end
        if (y > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    assign accept = in_valid && in_ready;
    assign yc0    = clamp(in_y0, min_y0, max_y0);
    assign yc1    = clamp(in_y1, min_y1, max_y1);

    assign rsh0 = {rem0_reg, num0_reg[NUM_W-1]};
    assign rsh1 = {rem1_reg, num1_reg[NUM_W-1]};
    assign ge0  = rsh0 >= {1'b0, den0_reg};
    assign ge1  = rsh1 >= {1'b0, den1_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == NUM_CNT_W'(NUM_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            F_IDLE:  in_ready = 1'b1;
            F_DIV:   ;
            F_PUSH:  push = !full;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == F_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= in_mode;
            t0_reg     <= in_target0;
            t1_reg     <= in_target1;
            num0_reg   <= NUM_W'(RES_Y0) * NUM_W'(yc0 - min_y0);
            num1_reg   <= NUM_W'(RES_Y1) * NUM_W'(yc1 - min_y1);
            den0_reg   <= max_y0 - min_y0;
            den1_reg   <= max_y1 - min_y1;
            empty0_reg <= max_y0 <= min_y0;
            empty1_reg <= max_y1 <= min_y1;
            rem0_reg   <= '0;
            rem1_reg   <= '0;
            quot0_reg  <= '0;
            quot1_reg  <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            // One quotient bit per cycle for both samples.
            num0_reg  <= {num0_reg[NUM_W-2:0], 1'b0};
            num1_reg  <= {num1_reg[NUM_W-2:0], 1'b0};
            quot0_reg <= {quot0_reg[NUM_W-2:0], ge0};
            quot1_reg <= {quot1_reg[NUM_W-2:0], ge1};
            rem0_reg  <= ge0 ? 16'(rsh0 - {1'b0, den0_reg}) : rsh0[15:0];
            rem1_reg  <= ge1 ? 16'(rsh1 - {1'b0, den1_reg}) : rsh1[15:0];
        end
    end

    always_comb
    begin
        job.mode    = mode_reg;
        job.target0 = t0_reg;
        job.target1 = t1_reg;
        if (empty0_reg)
        begin
            job.q0 = '0;
        end
        else if (quot0_reg >= NUM_W'(RES_Y0))
        begin
            job.q0 = LVL_W'(RES_Y0 - 1);
        end
        else
        begin
            job.q0 = quot0_reg[LVL_W-1:0];
        end
        if (empty1_reg)
        begin
            job.q1 = '0;
        end
        else if (quot1_reg >= NUM_W'(RES_Y1))
        begin
            job.q1 = LVL_W'(RES_Y1 - 1);
        end
        else
        begin
            job.q1 = quot1_reg[LVL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cmt_queue.sv =====
// Two-entry job queue between the quantizer front end and the cell sequencer.
// Depends on cmt_pkg for the job type.
`default_nettype none

module cmt_queue
    import cmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      full,
    output logic      empty
);

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = count_reg == QCNT_W'(QDEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("job pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("job popped from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count lost a push");

endmodule

`default_nettype wire

// ===== rtl/cmt_back.sv =====
// Cell sequencer: addresses the weight memories cell by cell, sums the
// weights, issues the result beat and applies training updates. Depends on cmt_pkg.
`default_nettype none

module cmt_back
    import cmt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  job_t              job,
    input  wire logic         empty,
    output logic              pop,
    input  wire logic [15:0]  learn_rate,
    input  wire logic [63:0]  disp_table,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [SUM_W-1:0]  out0,
    output logic [SUM_W-1:0]  out1,
    output logic [ERR_W-1:0]  error0,
    output logic [ERR_W-1:0]  error1
);

    back_state_t state_reg, state_next;

    job_t                    job_reg;
    logic [CELL_W-1:0]       cell_reg;
    logic [DSUM_W-1:0]       p0_reg, p1_reg;
    logic [ADDR_W-1:0]       addr_reg [NUM_CELLS];
    logic signed [SUM_W-1:0] sum0_reg, sum1_reg;
    logic [MAG_W-1:0]        div0_reg, div1_reg;
    logic [DREM_W-1:0]       drem0_reg, drem1_reg;
    logic                    neg0_reg, neg1_reg;
    logic [MAGCNT_W-1:0]     cnt_reg;
    logic                    out_valid_reg;
    logic [SUM_W-1:0]        out0_reg, out1_reg;
    logic [ERR_W-1:0]        err0_reg, err1_reg;

    logic [31:0]             mem0 [WEIGHT_DEPTH];
    logic [31:0]             mem1 [WEIGHT_DEPTH];
    logic [WEIGHT_DEPTH-1:0] vld_reg;
    logic [31:0]             rd0_reg, rd1_reg;
    logic                    rd_vld_reg;

    logic                    last_cell, load_out, rd_en, wr_en;
    logic [5:0]              pos0, pos1;
    logic [LIN_W-1:0]        lin;
    logic [ADDR_W-1:0]       addr_comb, rd_addr;
    logic signed [31:0]      w0, w1, nw0, nw1;
    logic signed [ERR_W-1:0] e0, e1;
    logic [MAG_W-1:0]        mag0, mag1;
    logic [MAG_W+15:0]       prod0, prod1;
    logic [DSH_W-1:0]        dsh0, dsh1;
    logic [DIV_DIGIT_W-1:0]  dq0, dq1;
    logic signed [INC_W-1:0] inc0, inc1;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] w,
                                                   input logic signed [INC_W-1:0] inc);
        logic signed [INC_W:0] s;
        logic signed [31:0]    r;
        s = (INC_W + 1)'(w) + (INC_W + 1)'(inc);
        if (s[INC_W:31] == '0 || s[INC_W:31] == '1)
        begin
            r = s[31:0];
        end
        else if (s[INC_W])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    assign last_cell = cell_reg == CELL_W'(NUM_CELLS - 1);
    assign pos0      = {3'(cell_reg), 1'b0, 2'b00};
    assign pos1      = {3'(cell_reg), 1'b1, 2'b00};
    assign lin       = LIN_W'(p0_reg) * LIN_W'(R1) + LIN_W'(p1_reg);
    assign addr_comb = lin[ADDR_W-1:0];
    assign rd_addr   = (state_reg == B_SUM_RD) ? addr_comb : addr_reg[cell_reg];

    // Entries never written since reset read as zero.
    assign w0 = rd_vld_reg ? rd0_reg : 32'sd0;
    assign w1 = rd_vld_reg ? rd1_reg : 32'sd0;

    assign e0 = job_reg.mode ? (ERR_W'(job_reg.target0) - ERR_W'(sum0_reg)) : '0;
    assign e1 = job_reg.mode ? (ERR_W'(job_reg.target1) - ERR_W'(sum1_reg)) : '0;

    assign mag0  = err0_reg[ERR_W-1] ? MAG_W'(-err0_reg) : err0_reg;
    assign mag1  = err1_reg[ERR_W-1] ? MAG_W'(-err1_reg) : err1_reg;
    assign prod0 = (MAG_W + 16)'(mag0) * (MAG_W + 16)'(learn_rate);
    assign prod1 = (MAG_W + 16)'(mag1) * (MAG_W + 16)'(learn_rate);

    assign dsh0 = {drem0_reg, div0_reg[MAG_W-1 -: DIV_DIGIT_W]};
    assign dsh1 = {drem1_reg, div1_reg[MAG_W-1 -: DIV_DIGIT_W]};
    assign dq0  = div_digit(dsh0);
    assign dq1  = div_digit(dsh1);

    assign inc0 = neg0_reg ? -$signed({1'b0, div0_reg}) : $signed({1'b0, div0_reg});
    assign inc1 = neg1_reg ? -$signed({1'b0, div1_reg}) : $signed({1'b0, div1_reg});
    assign nw0  = sat_add(w0, inc0);
    assign nw1  = sat_add(w1, inc1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_ADDR;
                end
            end
            B_ADDR:    state_next = B_SUM_RD;
            B_SUM_RD:  state_next = B_SUM_ACC;
            B_SUM_ACC: state_next = last_cell ? B_RESULT : B_ADDR;
            B_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = job_reg.mode ? B_INC : B_IDLE;
                end
            end
            B_INC:     state_next = B_DIV;
            B_DIV:
            begin
                if (cnt_reg == MAGCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = B_UPD_RD;
                end
            end
            B_UPD_RD:  state_next = B_UPD_WR;
            B_UPD_WR:  state_next = last_cell ? B_IDLE : B_UPD_RD;
            default:   state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        unique case (state_reg)
            B_IDLE:   pop = !empty;
            B_SUM_RD: rd_en = 1'b1;
            B_RESULT: load_out = !out_valid_reg || out_ready;
            B_UPD_RD: rd_en = 1'b1;
            B_UPD_WR: wr_en = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            cell_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                vld_reg[addr_reg[cell_reg]] <= 1'b1;
            end
            if (pop || (state_reg == B_RESULT))
            begin
                cell_reg <= '0;
            end
            else if ((state_reg == B_SUM_ACC) || (state_reg == B_UPD_WR))
            begin
                cell_reg <= cell_reg + 1'b1;
            end
            if (state_reg == B_INC)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == B_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg    <= mem0[rd_addr];
            rd1_reg    <= mem1[rd_addr];
            rd_vld_reg <= vld_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem0[addr_reg[cell_reg]] <= nw0;
            mem1[addr_reg[cell_reg]] <= nw1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= job;
            sum0_reg <= '0;
            sum1_reg <= '0;
        end
        if (state_reg == B_ADDR)
        begin
            p0_reg <= div_cells(DSUM_W'(job_reg.q0) + DSUM_W'(disp_table[pos0 +: 4]));
            p1_reg <= div_cells(DSUM_W'(job_reg.q1) + DSUM_W'(disp_table[pos1 +: 4]));
        end
        if (state_reg == B_SUM_RD)
        begin
            addr_reg[cell_reg] <= addr_comb;
        end
        if (state_reg == B_SUM_ACC)
        begin
            sum0_reg <= sum0_reg + SUM_W'(w0);
            sum1_reg <= sum1_reg + SUM_W'(w1);
        end
        if (load_out)
        begin
            out0_reg <= sum0_reg;
            out1_reg <= sum1_reg;
            err0_reg <= e0;
            err1_reg <= e1;
        end
        if (state_reg == B_INC)
        begin
            div0_reg  <= prod0[MAG_W+15:16];
            div1_reg  <= prod1[MAG_W+15:16];
            neg0_reg  <= err0_reg[ERR_W-1];
            neg1_reg  <= err1_reg[ERR_W-1];
            drem0_reg <= '0;
            drem1_reg <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            // Long division by the cell count, one twelve-bit digit per cycle,
            // each digit found by reciprocal multiplication.
            div0_reg  <= {div0_reg[MAG_W-DIV_DIGIT_W-1:0], dq0};
            div1_reg  <= {div1_reg[MAG_W-DIV_DIGIT_W-1:0], dq1};
            drem0_reg <= DREM_W'(dsh0 - DSH_W'(dq0) * DSH_W'(NUM_CELLS));
            drem1_reg <= DREM_W'(dsh1 - DSH_W'(dq1) * DSH_W'(NUM_CELLS));
        end
    end

    assign out_valid = out_valid_reg;
    assign out0      = out0_reg;
    assign out1      = out1_reg;
    assign error0    = err0_reg;
    assign error1    = err1_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
                     wr_en |-> (job_reg.mode && out_valid_reg == $past(out_valid_reg)
                                || job_reg.mode))
        else $error("weight write outside a training job");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> state_reg == B_IDLE)
        else $error("sequencer takes a new job while busy");
    assert property (@(posedge clk) disable iff (!rst_n) load_out |-> !rd_en && !wr_en)
        else $error("sequencer overlaps a result with memory access");

endmodule

`default_nettype wire

// ===== rtl/cmac_map_and_train_unit.sv =====
// CMAC map and train unit: two quantized inputs address NUM_CELLS weights per
// output; the weights are summed and, in train mode, updated toward the targets.
// The front end quantizes each input beat with a serial divider. For each cell, the
// cell sequencer forms the address, reads the weights and adds them; for a train
// beat it then multiplies the error by the learning rate, divides by the cell count
// and does a read and a write per cell on the single-port weight memories.
// The queue lets the next beat be quantized while the current one is sequenced.
// Depends on cmt_pkg, cmt_front, cmt_queue and cmt_back.
`default_nettype none

module cmac_map_and_train_unit
    import cmt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [95:0]          s_axis_tdata,   // y0, y1, target0, target1
    input  wire logic                 s_axis_tuser,   // mode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [143:0]              m_axis_tdata,   // out0, out1, error0, error1, pad
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    logic [15:0] min_y0_reg, max_y0_reg, min_y1_reg, max_y1_reg, learn_rate_reg;
    logic [63:0] disp_table_reg;

    job_t push_job, pop_job;
    logic push, pop, full, empty;
    logic [SUM_W-1:0] out0, out1;
    logic [ERR_W-1:0] error0, error1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_y0_reg     <= 16'd0;
            max_y0_reg     <= 16'd65535;
            min_y1_reg     <= 16'd0;
            max_y1_reg     <= 16'd65535;
            learn_rate_reg <= 16'd6554;
            disp_table_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_Y0:     min_y0_reg     <= cfg_data[15:0];
                CFG_MAX_Y0:     max_y0_reg     <= cfg_data[15:0];
                CFG_MIN_Y1:     min_y1_reg     <= cfg_data[15:0];
                CFG_MAX_Y1:     max_y1_reg     <= cfg_data[15:0];
                CFG_LEARN_RATE: learn_rate_reg <= cfg_data[15:0];
                CFG_DISP_TABLE: disp_table_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    cmt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_mode    (s_axis_tuser),
        .in_y0      (s_axis_tdata[15:0]),
        .in_y1      (s_axis_tdata[31:16]),
        .in_target0 (s_axis_tdata[63:32]),
        .in_target1 (s_axis_tdata[95:64]),
        .min_y0     (min_y0_reg),
        .max_y0     (max_y0_reg),
        .min_y1     (min_y1_reg),
        .max_y1     (max_y1_reg),
        .full       (full),
        .push       (push),
        .job        (push_job)
    );

    cmt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (full),
        .empty    (empty)
    );

    cmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (pop_job),
        .empty      (empty),
        .pop        (pop),
        .learn_rate (learn_rate_reg),
        .disp_table (disp_table_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out0       (out0),
        .out1       (out1),
        .error0     (error0),
        .error1     (error1)
    );

    assign m_axis_tdata = {2'b00, error1, error0, out1, out0};

endmodule

`default_nettype wire

// ===== verif/cmac_map_and_train_unit_test.sv =====
// Self-checking bench for the CMAC map and train unit: drives random and directed beats,
// predicts each result from its own copy of the weights and registers, and checks every field.
// Depends on cmt_pkg and the cmac_map_and_train_unit RTL.
`default_nettype none

module cmac_map_and_train_unit_test;
    import cmt_pkg::*;

    typedef struct packed {
        logic signed [35:0] error1;
        logic signed [35:0] error0;
        logic signed [34:0] out1;
        logic signed [34:0] out0;
    } cmac_result_t;

    class cmac_scoreboard;
        logic [15:0] lo0, hi0, lo1, hi1, rate;
        logic [63:0] disp_tab;
        logic signed [31:0] wt0 [WEIGHT_DEPTH];
        logic signed [31:0] wt1 [WEIGHT_DEPTH];
        cmac_result_t pending [$];
        int errors;

        function new();
            lo0 = 0; hi0 = 16'hFFFF; lo1 = 0; hi1 = 16'hFFFF; rate = 16'd6554;
            disp_tab = 0; errors = 0;
            foreach (wt0[i])
            begin
                wt0[i] = 0;
                wt1[i] = 0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
            case (idx)
                CFG_MIN_Y0: lo0 = v[15:0];
                CFG_MAX_Y0: hi0 = v[15:0];
                CFG_MIN_Y1: lo1 = v[15:0];
                CFG_MAX_Y1: hi1 = v[15:0];
                CFG_LEARN_RATE: rate = v[15:0];
                CFG_DISP_TABLE: disp_tab = v;
                default: ;
            endcase
        endfunction

        function int level(int y, int lo, int hi, int res);
            longint l;
            if (hi <= lo) return 0;
            if (y < lo) y = lo;
            if (y > hi) y = hi;
            l = (longint'(res) * (y - lo)) / (hi - lo);
            return (l >= res) ? res - 1 : int'(l);
        endfunction

        function longint weight_step(longint err);
            longint mag;
            mag = (err < 0) ? -err : err;
            mag = ((mag * rate) >>> 16) / NUM_CELLS;
            return (err < 0) ? -mag : mag;
        endfunction

        function longint sat32(longint s);
            if (s > 64'sd2147483647) return 64'sd2147483647;
            if (s < -64'sd2147483648) return -64'sd2147483648;
            return s;
        endfunction

        function void note_input(logic mode, logic [15:0] y0, logic [15:0] y1,
                                 logic signed [31:0] t0, logic signed [31:0] t1);
            int q0, q1, p0, p1;
            int a [NUM_CELLS];
            longint s0, s1, e0, e1, i0, i1;
            cmac_result_t r;
            q0 = level(y0, lo0, hi0, RES_Y0);
            q1 = level(y1, lo1, hi1, RES_Y1);
            s0 = 0; s1 = 0; e0 = 0; e1 = 0;
            for (int c = 0; c < NUM_CELLS; c++)
            begin
                p0 = (q0 + disp_tab[8*c +: 4]) / NUM_CELLS;
                p1 = (q1 + disp_tab[8*c+4 +: 4]) / NUM_CELLS;
                a[c] = (p0 * R1 + p1) % WEIGHT_DEPTH;
                s0 += wt0[a[c]];
                s1 += wt1[a[c]];
            end
            if (mode)
            begin
                e0 = longint'(t0) - s0;
                e1 = longint'(t1) - s1;
                i0 = weight_step(e0);
                i1 = weight_step(e1);
                for (int c = 0; c < NUM_CELLS; c++)
                begin
                    wt0[a[c]] = 32'(sat32(longint'(wt0[a[c]]) + i0));
                    wt1[a[c]] = 32'(sat32(longint'(wt1[a[c]]) + i1));
                end
            end
            r.out0 = 35'(s0); r.out1 = 35'(s1); r.error0 = 36'(e0); r.error1 = 36'(e1);
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic [143:0] data);
            cmac_result_t got, want;
            got = data[141:0];
            if (pending.size() == 0)
            begin
                report("unexpected beat", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.out0 !== want.out0) report("out0", got.out0, want.out0);
            if (got.out1 !== want.out1) report("out1", got.out1, want.out1);
            if (got.error0 !== want.error0) report("error0", got.error0, want.error0);
            if (got.error1 !== want.error1) report("error1", got.error1, want.error1);
            if (data[143:142] !== 2'b00) report("pad", data[143:142], 0);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = 0;
    logic s_axis_tuser = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [143:0] m_axis_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [63:0] cfg_data = 0;

    cmac_scoreboard board = new();
    int send_idle = 0;
    int recv_idle = 0;

    cmac_map_and_train_unit dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
        @(negedge clk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task send_sample(logic mode, logic [15:0] y0, logic [15:0] y1,
                     logic [31:0] t0, logic [31:0] t1);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) @(negedge clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {t1, t0, y1, y0};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_input(mode, y0, y1, t0, t1);
        @(negedge clk);
        s_axis_tvalid <= 0;
    endtask

    // Waits until every expected result has been received, then idles before returning.
    task drain;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (5 * NUM_CELLS + 60) @(posedge clk);
    endtask

    function logic [15:0] rnd_y();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [31:0] rnd_target();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(65535)) << 8;
            3: return -(32'($urandom_range(65535)) << 8);
            default: return $urandom;
        endcase
    endfunction

    task random_phase(int count);
        for (int n = 0; n < count; n++)
            send_sample($urandom_range(3) != 0, rnd_y(), rnd_y(), rnd_target(), rnd_target());
    endtask

    initial
    begin
        #400000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: field extremes, both modes, saturation and an empty range.
        send_sample(0, 16'h0000, 16'h0000, 0, 0);
        send_sample(0, 16'hFFFF, 16'hFFFF, 0, 0);
        send_sample(1, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int n = 0; n < 6; n++)
            send_sample(1, 16'h1234, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(1, 16'h1234, 16'h8000, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_LEARN_RATE, 16'hFFFF);
        write_reg(CFG_DISP_TABLE, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int n = 0; n < 8; n++)
            send_sample(1, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(1, 16'h0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        write_reg(CFG_MIN_Y0, 16'h8000);
        write_reg(CFG_MAX_Y0, 16'h8000);
        write_reg(CFG_MIN_Y1, 16'hFFFF);
        write_reg(CFG_MAX_Y1, 16'h0000);
        send_sample(0, 16'h9000, 16'h0001, 0, 0);
        send_sample(1, 16'h7000, 16'hFFFF, 32'h0001_0000, 32'hFFFF_0000);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 19 : (ph < 4) ? 64 : 0;
            recv_idle = (ph < 2) ? 64 : (ph < 4) ? 19 : 0;
            write_reg(CFG_MIN_Y0, (ph == 5) ? 16'h0000 : 16'($urandom_range(30000)));
            write_reg(CFG_MAX_Y0, (ph == 5) ? 16'hFFFF : 16'($urandom_range(65535, 30000)));
            write_reg(CFG_MIN_Y1, (ph == 0) ? 16'h0000 : 16'($urandom_range(30000)));
            write_reg(CFG_MAX_Y1, (ph == 0) ? 16'h0001 : 16'($urandom_range(65535, 30000)));
            write_reg(CFG_LEARN_RATE, (ph == 1) ? 16'h0000 : 16'($urandom));
            write_reg(CFG_DISP_TABLE, {$urandom, $urandom});
            random_phase(150);
            drain();
            random_phase(150);
            drain();
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
